FILE: rtl/core/jrx_pkg.sv
package jrx_pkg;

   // Result kinds carried on rsp_tuser
   localparam logic [2:0] KIND_NAME_START    = 3'd0;
   localparam logic [2:0] KIND_NAME_CHAR     = 3'd1;
   localparam logic [2:0] KIND_CONTENT_START = 3'd2;
   localparam logic [2:0] KIND_CONTENT_CHAR  = 3'd3;
   localparam logic [2:0] KIND_KEEP          = 3'd4;
   localparam logic [2:0] KIND_DROP          = 3'd5;
   localparam logic [2:0] KIND_DONE          = 3'd6;
   localparam logic [2:0] KIND_ERROR         = 3'd7;

   localparam int CHAR_W  = 16;
   localparam int COUNT_W = 16;

   typedef struct packed {
      logic               valid;
      logic [2:0]         kind;
      logic [CHAR_W-1:0]  value_char;
      logic [COUNT_W-1:0] kept_count;
   } result_type;

endpackage

FILE: rtl/core/jrx_parser.sv
module jrx_parser #(
   parameter int MAX_STR = 512
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [jrx_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                       fire,
   input  logic [jrx_pkg::CHAR_W-1:0] item_char,
   input  logic                       item_last,
   output jrx_pkg::result_type        result
);
   import jrx_pkg::*;

   localparam int LEN_W = $clog2(MAX_STR);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_STR - 1);

   localparam logic [3:0] M_BRACKET    = 4'd0;
   localparam logic [3:0] M_OUTER      = 4'd1;
   localparam logic [3:0] M_AFTER_OBJ  = 4'd2;
   localparam logic [3:0] M_INNER_WS   = 4'd3;
   localparam logic [3:0] M_INNER_TOP  = 4'd4;
   localparam logic [3:0] M_INNER_SKIP = 4'd5;
   localparam logic [3:0] M_AFTER_KEY  = 4'd6;
   localparam logic [3:0] M_BEFORE_VAL = 4'd7;
   localparam logic [3:0] M_AFTER_VAL  = 4'd8;
   localparam logic [3:0] M_STRING     = 4'd9;
   localparam logic [3:0] M_ESCAPE     = 4'd10;
   localparam logic [3:0] M_HEX        = 4'd11;
   localparam logic [3:0] M_HALT       = 4'd12;

   localparam logic [3:0] KM_START   = 4'd0;
   localparam logic [3:0] KM_NAME    = 4'd4;
   localparam logic [3:0] KM_CONTENT = 4'd11;
   localparam logic [3:0] KM_NONE    = 4'd15;

   localparam logic [1:0] TGT_NONE    = 2'd0;
   localparam logic [1:0] TGT_NAME    = 2'd1;
   localparam logic [1:0] TGT_CONTENT = 2'd2;
   localparam logic [1:0] TGT_KEY     = 2'd3;

   localparam logic [CHAR_W-1:0] CH_SPACE    = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_QUOTE    = 16'h0022;
   localparam logic [CHAR_W-1:0] CH_COMMA    = 16'h002C;
   localparam logic [CHAR_W-1:0] CH_COLON    = 16'h003A;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 16'h005B;
   localparam logic [CHAR_W-1:0] CH_BSLASH   = 16'h005C;
   localparam logic [CHAR_W-1:0] CH_LBRACE   = 16'h007B;
   localparam logic [CHAR_W-1:0] CH_RBRACE   = 16'h007D;

   function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= 16'h0030 && c <= 16'h0039) d = c[3:0];
      else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
         d = c[3:0] + 4'd9;
      return d;
   endfunction

   // walk one character through "name" (1..4) or "content" (5..11)
   function automatic logic [3:0] key_feed(input logic [3:0] km, input logic [CHAR_W-1:0] c);
      logic [3:0] r;
      r = KM_NONE;
      case (km)
         4'd0: begin
            if (c == 16'h006E) r = 4'd1;
            else if (c == 16'h0063) r = 4'd5;
         end
         4'd1:  if (c == 16'h0061) r = 4'd2;
         4'd2:  if (c == 16'h006D) r = 4'd3;
         4'd3:  if (c == 16'h0065) r = 4'd4;
         4'd5:  if (c == 16'h006F) r = 4'd6;
         4'd6:  if (c == 16'h006E) r = 4'd7;
         4'd7:  if (c == 16'h0074) r = 4'd8;
         4'd8:  if (c == 16'h0065) r = 4'd9;
         4'd9:  if (c == 16'h006E) r = 4'd10;
         4'd10: if (c == 16'h0074) r = 4'd11;
         default: r = KM_NONE;
      endcase
      return r;
   endfunction

   logic [COUNT_W-1:0] limit_ff;
   logic [3:0]         mode_ff, mode_in;
   logic [3:0]         km_ff, km_in;
   logic [1:0]         target_ff, target_in;
   logic               have_name_ff, have_name_in;
   logic               have_content_ff, have_content_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [CHAR_W-1:0]  hex_ff, hex_in;
   logic [2:0]         hex_left_ff, hex_left_in;
   logic [COUNT_W-1:0] kept_ff, kept_in;

   logic               ws;
   logic               after_value_go;
   logic               outer_go;
   logic               inner_top_go;
   logic               deliver_go;
   logic [CHAR_W-1:0]  deliver_ch;
   result_type         res;

   assign ws = (item_char <= CH_SPACE);

   always_comb begin
      mode_in         = mode_ff;
      km_in           = km_ff;
      target_in       = target_ff;
      have_name_in    = have_name_ff;
      have_content_in = have_content_ff;
      len_in          = len_ff;
      hex_in          = hex_ff;
      hex_left_in     = hex_left_ff;
      kept_in         = kept_ff;
      after_value_go  = 1'b0;
      outer_go        = 1'b0;
      inner_top_go    = 1'b0;
      deliver_go      = 1'b0;
      deliver_ch      = item_char;
      res             = '0;

      if (mode_ff == M_HALT) begin
         // stay halted until reset
      end else if (item_last) begin
         mode_in        = M_HALT;
         res.valid      = 1'b1;
         res.kind       = (mode_ff == M_BRACKET) ? KIND_ERROR : KIND_DONE;
         res.kept_count = kept_ff;
      end else begin
         unique case (mode_ff)
            M_BRACKET: begin
               if (!ws) begin
                  if (item_char == CH_LBRACKET) begin
                     mode_in = M_OUTER;
                  end else begin
                     mode_in        = M_HALT;
                     res.valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.kept_count = kept_ff;
                  end
               end
            end
            M_OUTER: begin
               outer_go = 1'b1;
            end
            M_AFTER_OBJ: begin
               if (!ws) begin
                  if (item_char == CH_COMMA) mode_in = M_OUTER;
                  else outer_go = 1'b1;
               end
            end
            M_INNER_WS: begin
               if (!ws) inner_top_go = 1'b1;
            end
            M_INNER_TOP: begin
               inner_top_go = 1'b1;
            end
            M_INNER_SKIP: begin
               if (!ws) begin
                  if (item_char == CH_QUOTE) begin
                     target_in = TGT_KEY;
                     km_in     = KM_START;
                     mode_in   = M_STRING;
                  end else begin
                     mode_in = M_INNER_TOP;
                  end
               end
            end
            M_AFTER_KEY: begin
               if (!ws) mode_in = (item_char == CH_COLON) ? M_BEFORE_VAL : M_INNER_TOP;
            end
            M_BEFORE_VAL: begin
               if (!ws) begin
                  if (item_char == CH_QUOTE) begin
                     len_in  = '0;
                     mode_in = M_STRING;
                     if (km_ff == KM_NAME) begin
                        target_in    = TGT_NAME;
                        have_name_in = 1'b1;
                        res.valid    = 1'b1;
                        res.kind     = KIND_NAME_START;
                     end else if (km_ff == KM_CONTENT) begin
                        target_in       = TGT_CONTENT;
                        have_content_in = 1'b1;
                        res.valid       = 1'b1;
                        res.kind        = KIND_CONTENT_START;
                     end else begin
                        target_in = TGT_NONE;
                     end
                  end else begin
                     after_value_go = 1'b1;
                  end
               end
            end
            M_AFTER_VAL: begin
               after_value_go = 1'b1;
            end
            M_STRING: begin
               if (item_char == CH_QUOTE) begin
                  mode_in = (target_ff == TGT_KEY) ? M_AFTER_KEY : M_AFTER_VAL;
               end else if (item_char == CH_BSLASH) begin
                  mode_in = M_ESCAPE;
               end else begin
                  deliver_go = 1'b1;
               end
            end
            M_ESCAPE: begin
               mode_in = M_STRING;
               case (item_char)
                  16'h0062: begin deliver_go = 1'b1; deliver_ch = 16'd8;  end
                  16'h0066: begin deliver_go = 1'b1; deliver_ch = 16'd12; end
                  16'h006E: begin deliver_go = 1'b1; deliver_ch = 16'd10; end
                  16'h0072: begin deliver_go = 1'b1; deliver_ch = 16'd13; end
                  16'h0074: begin deliver_go = 1'b1; deliver_ch = 16'd9;  end
                  16'h0075: begin
                     hex_in      = '0;
                     hex_left_in = 3'd4;
                     mode_in     = M_HEX;
                  end
                  default: deliver_go = 1'b1;
               endcase
            end
            M_HEX: begin
               hex_in      = {hex_ff[CHAR_W-5:0], hex_digit(item_char)};
               hex_left_in = hex_left_ff - 3'd1;
               if (hex_left_in == 3'd0) begin
                  mode_in    = M_STRING;
                  deliver_go = 1'b1;
                  deliver_ch = hex_in;
               end
            end
            default: begin
               mode_in = M_HALT;
            end
         endcase
      end

      if (after_value_go) begin
         if (ws) mode_in = M_AFTER_VAL;
         else if (item_char == CH_COMMA) mode_in = M_INNER_WS;
         else inner_top_go = 1'b1;
      end

      if (outer_go && !ws) begin
         if (kept_ff >= limit_ff || item_char != CH_LBRACE) begin
            mode_in        = M_HALT;
            res.valid      = 1'b1;
            res.kind       = KIND_DONE;
            res.kept_count = kept_ff;
         end else begin
            have_name_in    = 1'b0;
            have_content_in = 1'b0;
            mode_in         = M_INNER_WS;
         end
      end

      if (inner_top_go) begin
         if (item_char == CH_RBRACE) begin
            have_name_in    = 1'b0;
            have_content_in = 1'b0;
            mode_in         = M_AFTER_OBJ;
            res.valid       = 1'b1;
            if (have_name_ff && have_content_ff) begin
               kept_in  = kept_ff + 16'd1;
               res.kind = KIND_KEEP;
            end else begin
               res.kind = KIND_DROP;
            end
            res.kept_count = kept_in;
         end else if (ws) begin
            mode_in = M_INNER_SKIP;
         end else if (item_char == CH_QUOTE) begin
            target_in = TGT_KEY;
            km_in     = KM_START;
            mode_in   = M_STRING;
         end else begin
            mode_in = M_INNER_TOP;
         end
      end

      if (deliver_go) begin
         if (target_ff == TGT_KEY) begin
            km_in = key_feed(km_ff, deliver_ch);
         end else if (target_ff != TGT_NONE && len_ff < LEN_MAX) begin
            len_in         = len_ff + 1'b1;
            res.valid      = 1'b1;
            res.kind       = (target_ff == TGT_NAME) ? KIND_NAME_CHAR : KIND_CONTENT_CHAR;
            res.value_char = deliver_ch;
         end
      end
   end

   assign result = fire ? res : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff        <= 16'd64;
         mode_ff         <= M_BRACKET;
         km_ff           <= KM_START;
         target_ff       <= TGT_NONE;
         have_name_ff    <= 1'b0;
         have_content_ff <= 1'b0;
         len_ff          <= '0;
         hex_ff          <= '0;
         hex_left_ff     <= '0;
         kept_ff         <= '0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (fire) begin
            mode_ff         <= mode_in;
            km_ff           <= km_in;
            target_ff       <= target_in;
            have_name_ff    <= have_name_in;
            have_content_ff <= have_content_in;
            len_ff          <= len_in;
            hex_ff          <= hex_in;
            hex_left_ff     <= hex_left_in;
            kept_ff         <= kept_in;
         end
      end
   end

endmodule

FILE: rtl/core/json_record_extractor.sv
// Path: a character taken on req_ is held in the input register; its result is
//   registered in the result register and shown on rsp_.
// Throughput: one character per cycle unless rsp_ stalls; state updates once per character.
// Reset (synchronous, active high) returns the parser to waiting for the opening
//   bracket, clears the kept-record count and sets record_limit to 64.
module json_record_extractor #(
   parameter int MAX_STR = 512
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: record_limit
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] character
   input  logic        req_tlast,   // end_of_text
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] value_char, [31:16] kept_count
   output logic [2:0]  rsp_tuser    // [2:0] kind
);
   import jrx_pkg::*;

   // Input register: holds one character until the parser can take it.
   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_kind_ff;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic       rsp_open;
   logic       s1_fire;
   logic       req_fire;
   result_type result;

   // The result register can load when it is empty or its transfer completes now.
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   // The parser consumes the held character whenever the result slot is open;
   // characters that produce nothing still advance the state.
   assign s1_fire    = s1_valid_ff && rsp_open;
   assign req_tready = !s1_valid_ff || rsp_open;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) s1_valid_in = 1'b1;
      else if (s1_fire) s1_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_open) rsp_valid_in = result.valid;
   end

   jrx_parser #(
      .MAX_STR (MAX_STR)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (s1_fire),
      .item_char   (s1_char_ff),
      .item_last   (s1_last_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (rsp_open && result.valid) begin
         rsp_kind_ff  <= result.kind;
         rsp_char_ff  <= result.value_char;
         rsp_count_ff <= result.kept_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_char_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

FILE: rtl/core/jrx_checker.sv
module jrx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import jrx_pkg::*;

   logic halted_ff;
   logic rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // remember that a done or error went out
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
      end else if (rsp_fire && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_ERROR)) begin
         halted_ff <= 1'b1;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_silent_after_end: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !rsp_tvalid)
      else $error("result after done or error");

   a_char_only_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_NAME_CHAR && rsp_tuser != KIND_CONTENT_CHAR
      |-> rsp_tdata[15:0] == 16'd0)
      else $error("value_char set on a non-character result");

   a_keep_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_KEEP |-> rsp_tdata[31:16] != 16'd0)
      else $error("keep with zero kept count");

endmodule

bind json_record_extractor jrx_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
